/* rtl/audio_stutter_repeater_defines.svh */
// Assertion macros used by the checker file.
`ifndef AUDIO_STUTTER_REPEATER_DEFINES_SVH
`define AUDIO_STUTTER_REPEATER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/asr_pkg.sv */
package asr_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned RING_DEPTH_DEF  = 65536;
   localparam int unsigned SAMPLE_BITS_DEF = 24;

   // Control/status register port
   localparam int unsigned CSR_ADDR_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 17;
   localparam int unsigned LENGTH_BITS   = 17;

   localparam logic [CSR_ADDR_BITS-1:0] REG_ACTIVE = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] REG_LENGTH = CSR_ADDR_BITS'(1);

   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(16440);

   // Where a lane takes its output sample from
   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_RING,
      SRC_ZERO
   } asr_src_type;

   typedef struct packed {
      asr_src_type src;
      logic        looping;
   } asr_sel_type;

endpackage

/* rtl/asr_if.sv */
// Sample-pair input channel
interface asr_req_if #(
   parameter int unsigned SAMPLE_BITS = asr_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, left_in, right_in, input ready);
   modport sink   (input valid, left_in, right_in, output ready);
endinterface

// Sample-pair result channel
interface asr_rsp_if #(
   parameter int unsigned SAMPLE_BITS = asr_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          looping;

   modport source (output valid, left_out, right_out, looping, input ready);
   modport sink   (input valid, left_out, right_out, looping, output ready);
endinterface

// Register write channel
interface asr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [asr_pkg::CSR_ADDR_BITS-1:0] addr;
   logic [asr_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/asr_ram.sv */
module asr_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/asr_lane.sv */
module asr_lane #(
   parameter int unsigned SAMPLE_BITS = asr_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned RING_DEPTH  = asr_pkg::RING_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   input  logic                          wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  logic                          rd_en,
   input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   input  asr_pkg::asr_src_type          src,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);
   import asr_pkg::*;

   logic [SAMPLE_BITS-1:0]        ring_data;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in_d;

   // One channel of the ring
   asr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (sample_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ring_data)
   );

   // Input sample held beside the ring read; also the bypass on same-slot reads
   assign sample_in_d = load ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_d;
   end

   // Output select
   always_comb begin
      case (src)
         SRC_INPUT: sample_out = sample_ff;
         SRC_RING:  sample_out = ring_data;
         SRC_ZERO:  sample_out = '0;
         default:   sample_out = '0;
      endcase
   end

endmodule

/* rtl/asr_ctrl.sv */
module asr_ctrl #(
   parameter int unsigned RING_DEPTH = asr_pkg::RING_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [asr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [asr_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                               accept,
   output logic                               wr_en,
   output logic [$clog2(RING_DEPTH)-1:0]      wr_addr,
   output logic                               rd_en,
   output logic [$clog2(RING_DEPTH)-1:0]      rd_addr,
   output asr_pkg::asr_sel_type               sel
);
   import asr_pkg::*;

   localparam int unsigned AW      = $clog2(RING_DEPTH);
   localparam int unsigned LEN_CAP = (1 << LENGTH_BITS) - 1;
   localparam int unsigned LEN_MAX = (RING_DEPTH < LEN_CAP) ? RING_DEPTH : LEN_CAP;
   localparam int unsigned LW      = $clog2(LEN_MAX + 1);
   localparam int unsigned BW      = ((AW > LW) ? AW : LW) + 1;
   localparam logic [AW-1:0] LAST  = AW'(RING_DEPTH - 1);

   // Pointer and loop state
   logic                   active_ff,    active_in;
   logic [LENGTH_BITS-1:0] length_ff,    length_in;
   logic [AW-1:0]          wp_ff,        wp_in;
   logic [AW-1:0]          rp_ff,        rp_in;
   logic                   wrapped_ff,   wrapped_in;
   logic [LW-1:0]          phase_ff,     phase_in;
   logic [LW-1:0]          count_ff,     count_in;
   logic                   replaying_ff, replaying_in;

   logic [LW-1:0] len;
   logic [LW-1:0] count_inc;
   logic [LW-1:0] phase_inc;
   logic [AW-1:0] wp_inc;
   logic [AW-1:0] rp_inc;
   logic          step;

   // (p - n) modulo ring depth, for p below the depth and n up to it
   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
                                               input logic [LW-1:0] n);
      logic [BW-1:0] pw;
      logic [BW-1:0] nw;
      logic [BW-1:0] r;
      pw = BW'(p);
      nw = BW'(n);
      if (pw >= nw) begin
         r = pw - nw;
      end else begin
         r = pw + BW'(RING_DEPTH) - nw;
      end
      return r[AW-1:0];
   endfunction

   // Loop length clamped to 1..depth
   always_comb begin
      if (length_ff == '0) begin
         len = LW'(1);
      end else if (32'(length_ff) > 32'(RING_DEPTH)) begin
         len = LW'(RING_DEPTH);
      end else begin
         len = LW'(length_ff);
      end
   end

   assign step      = accept && active_ff;
   assign count_inc = count_ff + LW'(1);
   assign phase_inc = phase_ff + LW'(1);
   assign wp_inc    = (wp_ff == LAST) ? '0 : wp_ff + AW'(1);
   assign rp_inc    = (rp_ff == LAST) ? '0 : rp_ff + AW'(1);

   // Ring ports: write every active item, read the replay slot
   assign wr_en   = step;
   assign wr_addr = wp_ff;
   assign rd_addr = rp_ff;
   assign rd_en   = step && replaying_ff && (sel.src == SRC_RING);

   // Source select; a never-written slot reads as zero
   always_comb begin
      sel.looping = active_ff && replaying_ff;
      if (!sel.looping || (rp_ff == wp_ff)) begin
         sel.src = SRC_INPUT;
      end else if (wrapped_ff || (rp_ff < wp_ff)) begin
         sel.src = SRC_RING;
      end else begin
         sel.src = SRC_ZERO;
      end
   end

   // Next state: item step, then register writes
   always_comb begin
      active_in    = active_ff;
      length_in    = length_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      wrapped_in   = wrapped_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      replaying_in = replaying_ff;

      if (step) begin
         wp_in = wp_inc;
         if (wp_ff == LAST) begin
            wrapped_in = 1'b1;
         end
         if (!replaying_ff) begin
            count_in = count_inc;
            if (count_inc >= len) begin
               count_in     = '0;
               replaying_in = 1'b1;
               phase_in     = '0;
               rp_in        = ring_back(wp_ff, len);
            end
         end else begin
            phase_in = phase_inc;
            rp_in    = rp_inc;
            if (phase_inc >= len) begin
               phase_in = '0;
               rp_in    = ring_back(rp_inc, len);
            end
         end
      end

      if (csr_valid) begin
         if (csr_addr == REG_ACTIVE) begin
            active_in = csr_data[0];
            if (!csr_data[0]) begin
               replaying_in = 1'b0;
               phase_in     = '0;
               count_in     = '0;
            end
         end else if (csr_addr == REG_LENGTH) begin
            length_in = LENGTH_BITS'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         length_ff    <= LENGTH_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         phase_ff     <= '0;
         count_ff     <= '0;
         replaying_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         length_ff    <= length_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         wrapped_ff   <= wrapped_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         replaying_ff <= replaying_in;
      end
   end

endmodule

/* rtl/audio_stutter_repeater.sv */
// Channel   Direction  Transfer                  Payload
// req_chan  in         valid & ready             left_in, right_in
// rsp_chan  out        valid & ready             left_out, right_out, looping
// csr_chan  in         valid & ready (always 1)  addr (0 active, 1 length), data
//
// One sample pair per cycle sustained while the output is not stalled. A result passes
// one register stage for the ring read, then one for the output register, before it is
// valid on the output.
// Both lanes share one pointer controller; each lane owns one ring port pair.
// Reset is synchronous; the ring needs no clearing pass, unwritten slots read
// as zero through the write fill tracking. A stalled output holds the result
// and one item in the read stage; the input then stalls.
module audio_stutter_repeater #(
   parameter int unsigned RING_DEPTH  = asr_pkg::RING_DEPTH_DEF,
   parameter int unsigned SAMPLE_BITS = asr_pkg::SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   asr_req_if.sink    req_chan,
   asr_rsp_if.source  rsp_chan,
   asr_csr_if.sink    csr_chan
);
   import asr_pkg::*;

   localparam int unsigned AW = $clog2(RING_DEPTH);

   logic          accept;
   logic          out_adv;
   logic          s1_fire;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   asr_sel_type   sel;

   logic          s1_valid_ff, s1_valid_in;
   asr_sel_type   s1_sel_ff,   s1_sel_in;

   logic signed [SAMPLE_BITS-1:0] left_lane;
   logic signed [SAMPLE_BITS-1:0] right_lane;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff,  rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                          rsp_loop_ff,  rsp_loop_in;

   // Handshakes
   assign out_adv        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && out_adv;
   assign req_chan.ready = !s1_valid_ff || out_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   asr_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_addr  (csr_chan.addr),
      .csr_data  (csr_chan.data),
      .accept    (accept),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .sel       (sel)
   );

   asr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .RING_DEPTH  (RING_DEPTH)
   ) u_lane_left (
      .clock      (clock),
      .load       (accept),
      .sample_in  (req_chan.left_in),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .src        (s1_sel_ff.src),
      .sample_out (left_lane)
   );

   asr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .RING_DEPTH  (RING_DEPTH)
   ) u_lane_right (
      .clock      (clock),
      .load       (accept),
      .sample_in  (req_chan.right_in),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .src        (s1_sel_ff.src),
      .sample_out (right_lane)
   );

   // Read stage and merged output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sel_in    = s1_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_loop_in  = rsp_loop_ff;

      if (s1_fire) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_left_in  = left_lane;
         rsp_right_in = right_lane;
         rsp_loop_in  = s1_sel_ff.looping;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
         s1_sel_in   = sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_sel_ff    <= s1_sel_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_loop_ff  <= rsp_loop_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_out  = rsp_left_ff;
   assign rsp_chan.right_out = rsp_right_ff;
   assign rsp_chan.looping   = rsp_loop_ff;

endmodule

/* rtl/asr_checker.sv */
`include "audio_stutter_repeater_defines.svh"

module asr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_looping,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [asr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input logic [asr_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import asr_pkg::*;

   logic req_fire;
   logic active_ff, active_in;

   assign req_fire = req_valid && req_ready;

   // Mirror of the enable register from port writes
   always_comb begin
      active_in = active_ff;
      if (csr_valid && csr_ready && (csr_addr == REG_ACTIVE)) begin
         active_in = csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   `ASR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `ASR_ASSERT_NOW(a_loop_needs_active, clock, reset, rsp_valid && rsp_looping, active_ff, "replay output while disabled")
   `ASR_ASSERT_NEXT(a_latency, clock, reset, (req_fire ##1 rsp_ready), rsp_valid, "result late with open output")
   `ASR_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input blocked with empty output")

endmodule

bind audio_stutter_repeater asr_checker u_asr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_looping (rsp_chan.looping),
   .csr_valid   (csr_chan.valid),
   .csr_ready   (csr_chan.ready),
   .csr_addr    (csr_chan.addr),
   .csr_data    (csr_chan.data)
);

/* bench/tb_audio_stutter_repeater.sv */
module tb_audio_stutter_repeater;
   timeunit 1ns;
   timeprecision 1ps;

   import asr_pkg::*;

   localparam int unsigned RD = RING_DEPTH_DEF;
   localparam int unsigned SB = SAMPLE_BITS_DEF;

   localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   // One stereo result as the block should present it
   typedef struct {
      logic [SB-1:0] left;
      logic [SB-1:0] right;
      logic          looping;
   } stutter_pair_type;

   // Predicts the repeater and holds the results still owed by the block
   class stutter_scoreboard;
      logic [SB-1:0]    ring_left [RD];
      logic [SB-1:0]    ring_right [RD];
      int unsigned      wr_ptr;
      int unsigned      rd_ptr;
      int unsigned      loop_phase;
      int unsigned      capture_count;
      bit               replaying;
      bit               enabled;
      int unsigned      length_reg;
      stutter_pair_type owed_q [$];
      int unsigned      failures;

      function new();
         foreach (ring_left[i]) begin
            ring_left[i]  = '0;
            ring_right[i] = '0;
         end
         wr_ptr        = 0;
         rd_ptr        = 0;
         loop_phase    = 0;
         capture_count = 0;
         replaying     = 1'b0;
         enabled       = 1'b0;
         length_reg    = LENGTH_RESET;
         failures      = 0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10)
            $display("[%0t] %s", $realtime, what);
      endfunction

      // length register clamped to 1..ring depth
      function int unsigned loop_len();
         if (length_reg < 1)
            return 1;
         if (length_reg > RD)
            return RD;
         return length_reg;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == REG_ACTIVE) begin
            enabled = data[0];
            // turning off drops the loop and the capture count
            if (!enabled) begin
               replaying     = 1'b0;
               loop_phase    = 0;
               capture_count = 0;
            end
         end else if (idx == REG_LENGTH) begin
            length_reg = data;
         end
      endfunction

      function void note_input(logic [SB-1:0] l, logic [SB-1:0] r);
         stutter_pair_type e;
         int unsigned      len;
         e.left    = l;
         e.right   = r;
         e.looping = 1'b0;
         if (enabled) begin
            len = loop_len();
            ring_left[wr_ptr]  = l;
            ring_right[wr_ptr] = r;
            if (!replaying) begin
               // capture: the L-th pair still passes, then the loop starts
               capture_count++;
               if (capture_count >= len) begin
                  capture_count = 0;
                  replaying     = 1'b1;
                  loop_phase    = 0;
                  rd_ptr        = (wr_ptr + RD - len) % RD;
               end
            end else begin
               e.left    = ring_left[rd_ptr];
               e.right   = ring_right[rd_ptr];
               e.looping = 1'b1;
               rd_ptr    = (rd_ptr + 1) % RD;
               loop_phase++;
               if (loop_phase >= len) begin
                  loop_phase = 0;
                  rd_ptr     = (rd_ptr + RD - len) % RD;
               end
            end
            wr_ptr = (wr_ptr + 1) % RD;
         end
         owed_q = {owed_q, e};
      endfunction

      function void check_result(logic [SB-1:0] l, logic [SB-1:0] r, logic looping);
         stutter_pair_type e;
         if (owed_q.size() == 0) begin
            flag($sformatf("unexpected result L=%h R=%h loop=%b", l, r, looping));
            return;
         end
         e = owed_q.pop_front();
         if (e.left !== l || e.right !== r || e.looping !== looping)
            flag($sformatf("mismatch: exp L=%h R=%h loop=%b, got L=%h R=%h loop=%b",
                           e.left, e.right, e.looping, l, r, looping));
      endfunction

      function void check_drained();
         if (owed_q.size() != 0)
            flag($sformatf("%0d results never arrived", owed_q.size()));
      endfunction
   endclass

   logic clock;
   logic reset;

   asr_req_if #(.SAMPLE_BITS(SB)) req_chan ();
   asr_rsp_if #(.SAMPLE_BITS(SB)) rsp_chan ();
   asr_csr_if                     csr_chan ();

   audio_stutter_repeater #(
      .RING_DEPTH  (RD),
      .SAMPLE_BITS (SB)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   stutter_scoreboard sb = new();

   int unsigned items_sent = 0;
   int          burst_left = 0;
   bit          holdoff_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Watch every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready)
            sb.write_reg(csr_chan.addr, csr_chan.data);
         if (req_chan.valid && req_chan.ready)
            sb.note_input(req_chan.left_in, req_chan.right_in);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.left_out, rsp_chan.right_out, rsp_chan.looping);
      end
   end

   // Result side back-pressure
   initial begin
      int mode;
      int span;
      int hi;
      int lo;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         if (holdoff_req) begin
            // long hold-off so the block fills and stalls its input
            holdoff_req = 1'b0;
            for (int c = 0; c < 96; c++)
               @(negedge clock) rsp_chan.ready <= 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            hi   = $urandom_range(1, 5);
            lo   = $urandom_range(1, 4);
            for (int c = 0; c < span; c++) begin
               @(negedge clock);
               case (mode)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= 1'($urandom_range(0, 1));
                  2: rsp_chan.ready <= (c % (hi + lo)) < hi;
                  default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   function automatic logic [SB-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         default: return SB'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_length();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return $urandom_range(RD + 1, (1 << LENGTH_BITS) - 1);
         2, 3: return $urandom_range(41, 400);
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   // Offer one pair and hold it until the transfer; valid stays high
   task automatic send_pair(logic [SB-1:0] l, logic [SB-1:0] r);
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.left_in  <= l;
      req_chan.right_in <= r;
      do
         @(posedge clock);
      while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic quiet();
      @(negedge clock) req_chan.valid <= 1'b0;
   endtask

   // Random pairs, in bursts with random gaps between them when gaps is set
   task automatic run_items(int unsigned n, bit gaps);
      int gap;
      for (int unsigned i = 0; i < n; i++) begin
         if (gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               @(negedge clock) req_chan.valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         send_pair(pick_sample(), pick_sample());
         if (burst_left > 0)
            burst_left--;
      end
      quiet();
   endtask

   // Register write, only once the block has drained
   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] idx, int unsigned value);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= idx;
      csr_chan.data  <= CSR_DATA_BITS'(value);
      do
         @(posedge clock);
      while (!csr_chan.ready);
      @(negedge clock) csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int unsigned len;
      int unsigned n;
      int unsigned start;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.left_in  = '0;
      req_chan.right_in = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.addr     = REG_ACTIVE;
      csr_chan.data     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // inactive: straight through, extremes of both lanes
      send_pair(SAMPLE_MAX, SAMPLE_MIN);
      send_pair(SAMPLE_MIN, SAMPLE_MAX);
      quiet();
      // active with the reset length: still capturing, passes through
      write_reg(REG_ACTIVE, 1);
      send_pair('1, '0);
      send_pair(24'h5A5A5A, 24'hA5A5A5);
      quiet();
      // length 0 acts as 1; count already past it, so the loop starts now
      write_reg(REG_LENGTH, 0);
      send_pair(24'h000001, 24'hFFFFFE);
      send_pair(24'h123456, 24'h654321);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      quiet();
      // re-enabling while enabled keeps the loop running
      write_reg(REG_ACTIVE, 1);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair('0, '1);
      quiet();
      // longer loop while it runs: the phase counts on to the new length
      write_reg(REG_LENGTH, 3);
      for (int i = 0; i < 5; i++)
         send_pair(pick_sample(), pick_sample());
      quiet();
      // disabled: no ring write, no pointer moves
      write_reg(REG_ACTIVE, 0);
      send_pair(24'h7F0000, 24'h80FFFF);
      send_pair(24'h00FF00, 24'hFF00FF);
      quiet();
      write_reg(REG_LENGTH, 2);
      write_reg(REG_ACTIVE, 1);
      for (int i = 0; i < 5; i++)
         send_pair(pick_sample(), pick_sample());
      quiet();

      // output held off for a long stretch while pairs keep coming
      holdoff_req = 1'b1;
      while (holdoff_req)
         @(negedge clock);
      run_items(40, 1'b0);

      // random phases of capture and replay, mostly short loops
      start = items_sent;
      while (items_sent - start < 1200) begin
         len = pick_length();
         if ($urandom_range(0, 1))
            write_reg(REG_ACTIVE, 0);
         write_reg(REG_LENGTH, len);
         write_reg(REG_ACTIVE, 1);
         n = (len == 0) ? $urandom_range(1, 6)
                        : len * $urandom_range(1, 4) + $urandom_range(0, len);
         if (n > 300)
            n = $urandom_range(100, 300);
         run_items(n, 1'b1);
         // length change while the loop runs
         if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_LENGTH, $urandom_range(1, 40));
            if ($urandom_range(0, 3) == 0)
               write_reg(REG_ACTIVE, 1);
            run_items($urandom_range(1, 80), 1'b1);
         end
         if ($urandom_range(0, 1)) begin
            write_reg(REG_ACTIVE, 0);
            run_items($urandom_range(0, 8), 1'b1);
         end
      end

      write_reg(REG_ACTIVE, 0);
      run_items(10, 1'b1);

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      sb.check_drained();
      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/asr_pkg.sv
rtl/asr_if.sv
rtl/asr_ram.sv
rtl/asr_lane.sv
rtl/asr_ctrl.sv
rtl/audio_stutter_repeater.sv
rtl/asr_checker.sv
bench/tb_audio_stutter_repeater.sv
